// ===== rtl/cgm_pkg.sv =====
package cgm_pkg;

    // Fixed field widths
    localparam int IDX_W  = 19;
    localparam int POS_W  = 17;
    localparam int NRM_W  = 2;
    localparam int TEX_W  = 17;
    localparam int CODE_W = 2;
    localparam int GRID_W = 8;
    localparam int CFG_W  = 8;
    localparam int CFG_IDX_W = 1;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 152;
    localparam int M_TUSER_W = 2;

    // Divider: 18 quotient bits, two per cycle
    localparam int QW             = 18;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_STEPS      = QW / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int NUM_SIDES = 6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_U = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_V = 1'b1;

    localparam logic [CFG_W-1:0] CELLS_RESET = 8'd8;

    // Record codes: bit0 triangle, bit1 last
    localparam logic [CODE_W-1:0] REC_VERTEX      = 2'b00;
    localparam logic [CODE_W-1:0] REC_TRI         = 2'b01;
    localparam logic [CODE_W-1:0] REC_VERTEX_LAST = 2'b10;
    localparam logic [CODE_W-1:0] REC_TRI_LAST    = 2'b11;

    localparam logic [TEX_W-1:0]        HALF_Q16_U = 17'd32768;
    localparam logic signed [POS_W-1:0] HALF_Q16   = 17'sd32768;
    localparam logic signed [NRM_W-1:0] NRM_POS    = 2'sb01;
    localparam logic signed [NRM_W-1:0] NRM_NEG    = 2'sb11;
    localparam logic signed [NRM_W-1:0] NRM_ZERO   = 2'sb00;

    typedef enum logic [2:0] {
        SIDE_FRONT,
        SIDE_BACK,
        SIDE_RIGHT,
        SIDE_LEFT,
        SIDE_TOP,
        SIDE_BOTTOM
    } side_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_VERTEX,
        BK_TRI
    } back_state_t;

    // One classified grid point, front to back
    typedef struct packed {
        logic [TEX_W-1:0] s;
        logic [TEX_W-1:0] t;
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] per_side;
        logic [IDX_W-1:0] nu;
        logic             tris;
    } q_entry_t;

    // One result record
    typedef struct packed {
        logic [CODE_W-1:0]        code;
        logic [IDX_W-1:0]         index_a;
        logic [IDX_W-1:0]         index_b;
        logic [IDX_W-1:0]         index_c;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [NRM_W-1:0]  norm_x;
        logic signed [NRM_W-1:0]  norm_y;
        logic signed [NRM_W-1:0]  norm_z;
        logic [TEX_W-1:0]         tex_s;
        logic [TEX_W-1:0]         tex_t;
    } out_rec_t;

endpackage

// ===== rtl/cgm_div.sv =====
module cgm_div #(
    parameter int DW = 9
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DW-1:0]        divisor,
    input  logic [DW-1:0]        rem_init,
    input  logic [cgm_pkg::QW-1:0] dividend_lo,
    output logic                 busy,
    output logic                 valid,
    output logic [cgm_pkg::QW-1:0] quotient
);
    import cgm_pkg::*;

    logic [DW-1:0]        rem_reg, rem_next;
    logic [QW-1:0]        num_reg, num_next;
    logic [QW-1:0]        q_reg, q_next;
    logic [DW-1:0]        div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 valid_reg;
    logic [DW:0]          trial;

    // Restoring division, two quotient bits per cycle
    always_comb begin
        rem_next = rem_reg;
        num_next = num_reg;
        q_next   = q_reg;
        trial    = '0;
        for (int i = 0; i < DIV_RADIX_BITS; i++) begin
            trial    = {rem_next, num_next[QW-1]};
            num_next = {num_next[QW-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = DW'(trial - {1'b0, div_reg});
                q_next   = {q_next[QW-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                q_next   = {q_next[QW-2:0], 1'b0};
            end
        end
    end

    // Step counter and status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            num_reg <= dividend_lo;
            div_reg <= divisor;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            q_reg   <= q_next;
        end
    end

    assign busy     = busy_reg;
    assign valid    = valid_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/cgm_front.sv =====
module cgm_front #(
    parameter int MAX_CELLS = 255
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [cgm_pkg::CFG_W-1:0]     cells_u,
    input  logic [cgm_pkg::CFG_W-1:0]     cells_v,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cgm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          q_full,
    output logic                          q_push,
    output cgm_pkg::q_entry_t             q_entry
);
    import cgm_pkg::*;

    localparam int CW = $clog2(MAX_CELLS + 1);

    function automatic logic [CW-1:0] clamp_cells(input logic [CFG_W-1:0] c);
        logic [CW-1:0] r;
        if (c == '0) begin
            r = CW'(1);
        end else if (32'(c) > MAX_CELLS) begin
            r = CW'(MAX_CELLS);
        end else begin
            r = CW'(c);
        end
        return r;
    endfunction

    logic [CW-1:0]     cu_c, cv_c, u_c, v_c;
    logic [GRID_W-1:0] u_in, v_in;
    logic              accept;
    logic              pending_reg;
    logic [CW-1:0]     u_reg, v_reg;
    logic [CW:0]       nu_reg, cv1_reg;
    logic              tris_reg;
    logic [2*CW:0]     nuv_prod;
    logic [2*CW+1:0]   side_prod;
    logic [IDX_W-1:0]  nuv_reg, per_side_reg;
    logic              div_busy_u, div_busy_v;
    logic              div_valid_u, div_valid_v;
    logic [QW-1:0]     q_u, q_v;

    // Clamp counts and coordinates
    assign u_in = s_tdata[GRID_W-1:0];
    assign v_in = s_tdata[2*GRID_W-1:GRID_W];
    assign cu_c = clamp_cells(cells_u);
    assign cv_c = clamp_cells(cells_v);
    assign u_c  = (32'(u_in) > 32'(cu_c)) ? cu_c : CW'(u_in);
    assign v_c  = (32'(v_in) > 32'(cv_c)) ? cv_c : CW'(v_in);

    // One item in the dividers at a time; the next one enters as this one leaves
    assign q_push   = pending_reg && div_valid_u && div_valid_v && !q_full;
    assign s_tready = !pending_reg || q_push;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
        end else if (accept) begin
            pending_reg <= 1'b1;
        end else if (q_push) begin
            pending_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            u_reg    <= u_c;
            v_reg    <= v_c;
            nu_reg   <= {1'b0, cu_c} + 1'b1;
            cv1_reg  <= {1'b0, cv_c} + 1'b1;
            tris_reg <= (u_c < cu_c) && (v_c < cv_c);
        end
    end

    // Row offset and side stride, ready long before the quotients
    assign nuv_prod  = nu_reg * v_reg;
    assign side_prod = nu_reg * cv1_reg;

    always_ff @(posedge aclk) begin
        nuv_reg      <= IDX_W'(nuv_prod);
        per_side_reg <= IDX_W'(side_prod);
    end

    // s = (u*2^17 + cu) / (2*cu), t likewise
    cgm_div #(.DW(CW + 1)) u_div_s (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (accept),
        .divisor     ({cu_c, 1'b0}),
        .rem_init    ((CW + 1)'(u_c >> 1)),
        .dividend_lo ({u_c[0], TEX_W'(cu_c)}),
        .busy        (div_busy_u),
        .valid       (div_valid_u),
        .quotient    (q_u)
    );

    cgm_div #(.DW(CW + 1)) u_div_t (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (accept),
        .divisor     ({cv_c, 1'b0}),
        .rem_init    ((CW + 1)'(v_c >> 1)),
        .dividend_lo ({v_c[0], TEX_W'(cv_c)}),
        .busy        (div_busy_v),
        .valid       (div_valid_v),
        .quotient    (q_v)
    );

    // Entry for the back end; valid drops once a new item starts
    always_comb begin
        q_entry.s        = q_u[TEX_W-1:0];
        q_entry.t        = q_v[TEX_W-1:0];
        q_entry.p        = nuv_reg + IDX_W'(u_reg);
        q_entry.per_side = per_side_reg;
        q_entry.nu       = IDX_W'(nu_reg);
        q_entry.tris     = tris_reg && !(div_busy_u || div_busy_v);
    end

endmodule

// ===== rtl/cgm_queue.sv =====
module cgm_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  cgm_pkg::q_entry_t push_entry,
    input  logic              pop,
    output cgm_pkg::q_entry_t head,
    output logic              full,
    output logic              empty
);
    import cgm_pkg::*;

    q_entry_t             slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;

    assign full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/cgm_back.sv =====
module cgm_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  cgm_pkg::q_entry_t q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output cgm_pkg::out_rec_t m_rec
);
    import cgm_pkg::*;

    back_state_t       state_reg, state_next;
    side_t             side_reg, side_next;
    logic              half_reg, half_next;
    logic [IDX_W-1:0]  bp_reg, bp_next;
    q_entry_t          ent_reg;
    logic              out_valid_reg;
    out_rec_t          out_rec_reg;
    out_rec_t          rec;
    logic              out_load;
    logic              adv;
    logic              last_rec;
    logic              take;
    logic signed [POS_W-1:0] a_pos, b_pos, a_neg, b_neg;

    // Output register frees when empty or taken
    assign out_load = !out_valid_reg || m_ready;
    assign adv      = (state_reg != BK_IDLE) && out_load;
    assign last_rec = (side_reg == SIDE_BOTTOM) &&
                      (((state_reg == BK_VERTEX) && !ent_reg.tris) ||
                       ((state_reg == BK_TRI) && half_reg));
    assign take     = !q_empty && ((state_reg == BK_IDLE) || (adv && last_rec));
    assign q_pop    = take;

    // Next state and walk over sides
    always_comb begin
        state_next = state_reg;
        side_next  = side_reg;
        half_next  = half_reg;
        bp_next    = bp_reg;
        if (take) begin
            state_next = BK_VERTEX;
            side_next  = SIDE_FRONT;
            half_next  = 1'b0;
            bp_next    = q_head.p;
        end else if (adv) begin
            unique case (state_reg)
                BK_VERTEX: begin
                    if (side_reg == SIDE_BOTTOM) begin
                        state_next = ent_reg.tris ? BK_TRI : BK_IDLE;
                        side_next  = SIDE_FRONT;
                        half_next  = 1'b0;
                        bp_next    = ent_reg.p;
                    end else begin
                        side_next = side_t'(side_reg + 1'b1);
                        bp_next   = bp_reg + ent_reg.per_side;
                    end
                end
                BK_TRI: begin
                    if (half_reg) begin
                        half_next = 1'b0;
                        if (side_reg == SIDE_BOTTOM) begin
                            state_next = BK_IDLE;
                        end else begin
                            side_next = side_t'(side_reg + 1'b1);
                            bp_next   = bp_reg + ent_reg.per_side;
                        end
                    end else begin
                        half_next = 1'b1;
                    end
                end
                default: begin
                    state_next = BK_IDLE;
                end
            endcase
        end
    end

    // Record for the current step
    assign a_pos = $signed(ent_reg.s - HALF_Q16_U);
    assign b_pos = $signed(ent_reg.t - HALF_Q16_U);
    assign a_neg = -a_pos;
    assign b_neg = -b_pos;

    always_comb begin
        rec = '0;
        unique case (state_reg)
            BK_VERTEX: begin
                rec.code    = last_rec ? REC_VERTEX_LAST : REC_VERTEX;
                rec.index_a = bp_reg;
                rec.tex_s   = ent_reg.s;
                rec.tex_t   = ent_reg.t;
                unique case (side_reg)
                    SIDE_FRONT: begin
                        rec.pos_x  = a_pos;
                        rec.pos_y  = b_pos;
                        rec.pos_z  = HALF_Q16;
                        rec.norm_z = NRM_POS;
                    end
                    SIDE_BACK: begin
                        rec.pos_x  = a_neg;
                        rec.pos_y  = b_pos;
                        rec.pos_z  = -HALF_Q16;
                        rec.norm_z = NRM_NEG;
                    end
                    SIDE_RIGHT: begin
                        rec.pos_x  = HALF_Q16;
                        rec.pos_y  = b_neg;
                        rec.pos_z  = a_pos;
                        rec.norm_x = NRM_POS;
                    end
                    SIDE_LEFT: begin
                        rec.pos_x  = -HALF_Q16;
                        rec.pos_y  = b_pos;
                        rec.pos_z  = a_pos;
                        rec.norm_x = NRM_NEG;
                    end
                    SIDE_TOP: begin
                        rec.pos_x  = a_pos;
                        rec.pos_y  = HALF_Q16;
                        rec.pos_z  = b_neg;
                        rec.norm_y = NRM_POS;
                    end
                    SIDE_BOTTOM: begin
                        rec.pos_x  = a_pos;
                        rec.pos_y  = -HALF_Q16;
                        rec.pos_z  = b_pos;
                        rec.norm_y = NRM_NEG;
                    end
                    default: begin
                        rec.norm_x = NRM_ZERO;
                    end
                endcase
            end
            BK_TRI: begin
                rec.code    = last_rec ? REC_TRI_LAST : REC_TRI;
                // first (p, p+1, p+n), second (p+n, p+1, p+n+1)
                rec.index_a = half_reg ? bp_reg + ent_reg.nu : bp_reg;
                rec.index_b = bp_reg + 1'b1;
                rec.index_c = half_reg ? bp_reg + ent_reg.nu + 1'b1 : bp_reg + ent_reg.nu;
            end
            default: begin
                rec.code = REC_VERTEX;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            side_reg      <= SIDE_FRONT;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            side_reg  <= side_next;
            half_reg  <= half_next;
            if (out_load) begin
                out_valid_reg <= (state_reg != BK_IDLE);
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        bp_reg <= bp_next;
        if (take) begin
            ent_reg <= q_head;
        end
        if (adv) begin
            out_rec_reg <= rec;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_rec   = out_rec_reg;

endmodule

// ===== rtl/cube_grid_mesh_generator_unit.sv =====
// Cube face grid mesh generator.
// Input stream (s_*): one grid point per item, grid_u and grid_v, clamped
// to the cell counts. Output stream (m_*): six vertex records per point in
// side order front, back, right, left, top, bottom, followed by twelve
// triangle records (two per side) when the point is the lower corner of a
// cell. m_tuser carries the record code; its bit 1 flags the last record.
// Configuration: cfg_wr_en with cfg_wr_index 0 writes cells_u, 1 cells_v;
// write only while no item is in flight.
// Two radix-4 dividers form s and t; the entry for an item is queued once
// both quotients are valid, and its records leave by the output register.
// The single output register issues one record per cycle while m_tready is
// high, so it sets the pace for an interior point; for a point on the far
// edge the divider iteration sets the pace. A two-entry queue sits between the
// divider front end and the record sequencer, so the front end works on
// the next point while records of earlier ones are still going out.
// Reset: cell counts return to 8, queue and output empty, no clearing pass.
// A stalled m_tready holds the current record; the queue then fills and
// s_tready drops.
module cube_grid_mesh_generator_unit #(
    parameter int MAX_CELLS = 255
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cgm_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [cgm_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // grid_u[7:0], grid_v[15:8]
    input  logic [cgm_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // index_a[18:0], index_b[37:19], index_c[56:38], pos_x[73:57],
    // pos_y[90:74], pos_z[107:91], norm_x[109:108], norm_y[111:110],
    // norm_z[113:112], tex_s[130:114], tex_t[147:131], zero[151:148]
    output logic [cgm_pkg::M_TDATA_W-1:0] m_tdata,
    // record_code[1:0]
    output logic [cgm_pkg::M_TUSER_W-1:0] m_tuser
);
    import cgm_pkg::*;

    logic [CFG_W-1:0] cells_u_reg, cells_v_reg;
    logic             q_push, q_pop, q_full, q_empty;
    q_entry_t         push_entry, head_entry;
    out_rec_t         rec;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cells_u_reg <= CELLS_RESET;
            cells_v_reg <= CELLS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_CELLS_U: cells_u_reg <= cfg_wr_data;
                REG_CELLS_V: cells_v_reg <= cfg_wr_data;
                default: begin
                    cells_u_reg <= cells_u_reg;
                end
            endcase
        end
    end

    cgm_front #(.MAX_CELLS(MAX_CELLS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cells_u  (cells_u_reg),
        .cells_v  (cells_v_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    cgm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    cgm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (head_entry),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_rec   (rec)
    );

    // Pack the record
    assign m_tdata = {4'b0000, rec.tex_t, rec.tex_s,
                      rec.norm_z, rec.norm_y, rec.norm_x,
                      rec.pos_z, rec.pos_y, rec.pos_x,
                      rec.index_c, rec.index_b, rec.index_a};
    assign m_tuser = rec.code;

endmodule
